@@ src/fsmlc_pkg.sv @@
// package: shared types, constants and register codes for the string matcher
package fsmlc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int PAT_IDX_W       = 4;
    localparam int LEN_W           = 5;
    localparam int LINE_W          = 24;
    localparam int COL_W           = 16;
    localparam int CNT_W           = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = 2;

    localparam logic [7:0]        NEWLINE_BYTE = 8'h0A;
    localparam logic [LINE_W-1:0] LINE_MAX     = '1;
    localparam logic [COL_W-1:0]  COL_MAX      = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic              is_end;
        logic [LINE_W-1:0] match_line;
        logic [COL_W-1:0]  match_column;
        logic [CNT_W-1:0]  match_total;
        logic              last_result;
    } result_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } pos_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } result_pair_t;

endpackage

@@ src/fsmlc_cell.sv @@
// window cell: holds one recent byte with its position and compares the byte entering it
module fsmlc_cell
    import fsmlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic       clear,
    input  logic [7:0] d_byte,
    input  pos_t       d_pos,
    input  logic       d_valid,
    input  logic [7:0] pat_byte,
    input  logic       in_use,
    output logic [7:0] q_byte,
    output pos_t       q_pos,
    output logic       q_valid,
    output logic       ok
);

    logic [7:0] byte_reg;
    pos_t       pos_reg;
    logic       valid_reg;
    logic       valid_next;

    assign ok = !in_use || (d_valid && (d_byte == pat_byte));

    assign valid_next = shift ? (d_valid && !clear) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= d_byte;
            pos_reg  <= d_pos;
        end
    end

    assign q_byte  = byte_reg;
    assign q_pos   = pos_reg;
    assign q_valid = valid_reg;

endmodule

@@ src/fsmlc_fifo.sv @@
// result queue: stores one or two results per request and hands them out one at a time
module fsmlc_fifo
    import fsmlc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  result_pair_t push_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_t      result
);

    result_pair_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   head_reg, head_next;
    logic [FIFO_PTR_W-1:0]   tail_reg, tail_next;
    logic [FIFO_PTR_W:0]     count_reg, count_next;
    logic                    sub_reg, sub_next;
    result_pair_t            head_entry;
    logic                    do_push;
    logic                    pop;
    logic                    pop_entry;

    assign push_ready   = (count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign do_push      = push_valid && push_ready;
    assign head_entry   = mem_reg[head_reg];
    assign result_valid = (count_reg != '0);
    assign result       = sub_reg ? head_entry.second : head_entry.first;
    assign pop          = result_valid && result_ready;
    assign pop_entry    = pop && (sub_reg || !head_entry.two);

    always_comb
    begin
        tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
        head_next  = pop_entry ? head_reg + 1'b1 : head_reg;
        sub_next   = pop ? !pop_entry : sub_reg;
        count_next = count_reg + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(pop_entry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

endmodule

@@ src/fixed_string_match_line_column.sv @@
// top level: fixed string search over a byte stream with line and column tracking
//
// Bytes of a file arrive on the item channel, one request per byte, with
// last_byte set on the final byte. A pattern of 1 to 16 bytes is set on the
// cfg channel (length, bytes 0..7, bytes 8..15), by the user only while the
// block is idle; the block does not enforce this. Every occurrence,
// overlapping ones included, yields a result with the line and column of
// its first byte; the final byte also yields an end marker with the match
// count, and the line, column and window restart for the next file.
// One byte is taken per cycle while the queue has room: the window is a row
// of cells that shift the bytes along and compare them with the pattern in
// parallel. Results are registered into a 4-entry queue and appear on the
// result channel from there; a byte that yields two results has them handed
// out one at a time. item_ready drops only while that queue is full, so a
// stalled receiver holds off new bytes after at most four pending requests.
// Reset sets the pattern length to 1 with all pattern bytes zero, empties
// the window and the queue, and starts at line 1, column 1.
module fixed_string_match_line_column
    import fsmlc_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LINE_W-1:0]     line_reg, line_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      mc_reg, mc_next, mc_inc;

    logic [8*PAT_BYTES-1:0] pat_flat;
    logic [LEN_W-1:0]       len_eff;
    logic                   accept;
    logic                   hit;
    pos_t                   hit_pos;
    logic                   push_ready;
    logic                   push_valid;
    result_pair_t           pair;
    result_t                match_res;
    result_t                end_res;

    logic [7:0]             d_byte  [MAX_PATTERN];
    pos_t                   d_pos   [MAX_PATTERN];
    logic                   d_valid [MAX_PATTERN];
    logic [7:0]             pat_b   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] in_use;
    logic [MAX_PATTERN-1:0] ok;

    assign cfg_ready  = 1'b1;
    assign item_ready = push_ready;
    assign accept     = item_valid && item_ready;
    assign pat_flat   = {pat_high_reg, pat_low_reg};

    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: len_reg      <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // head of the chain takes the incoming byte at the current position
    assign d_byte[0]  = item.data_byte;
    assign d_pos[0]   = '{line: line_reg, column: col_reg};
    assign d_valid[0] = 1'b1;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [LEN_W-1:0] sel;

        assign sel       = len_eff - LEN_W'(j + 1);
        assign in_use[j] = (LEN_W'(j) < len_eff);
        assign pat_b[j]  = pat_flat[{sel[PAT_IDX_W-1:0], 3'b000} +: 8];

        if (j < MAX_PATTERN - 1)
        begin : g_mid
            fsmlc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .clear    (item.last_byte),
                .d_byte   (d_byte[j]),
                .d_pos    (d_pos[j]),
                .d_valid  (d_valid[j]),
                .pat_byte (pat_b[j]),
                .in_use   (in_use[j]),
                .q_byte   (d_byte[j+1]),
                .q_pos    (d_pos[j+1]),
                .q_valid  (d_valid[j+1]),
                .ok       (ok[j])
            );
        end
        else
        begin : g_tail
            fsmlc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .clear    (item.last_byte),
                .d_byte   (d_byte[j]),
                .d_pos    (d_pos[j]),
                .d_valid  (d_valid[j]),
                .pat_byte (pat_b[j]),
                .in_use   (in_use[j]),
                .q_byte   (),
                .q_pos    (),
                .q_valid  (),
                .ok       (ok[j])
            );
        end
    end

    assign hit = &ok;

    // position of the oldest byte in the match
    always_comb
    begin
        hit_pos = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (LEN_W'(j + 1) == len_eff)
            begin
                hit_pos = d_pos[j];
            end
        end
    end

    assign mc_inc = (hit && (mc_reg != CNT_MAX)) ? mc_reg + 1'b1 : mc_reg;

    always_comb
    begin
        match_res = '{is_end: 1'b0, match_line: hit_pos.line, match_column: hit_pos.column,
                      match_total: '0, last_result: !item.last_byte};
        end_res   = '{is_end: 1'b1, match_line: '0, match_column: '0,
                      match_total: mc_inc, last_result: 1'b1};
        pair.two    = hit && item.last_byte;
        pair.first  = hit ? match_res : end_res;
        pair.second = end_res;
        push_valid  = accept && (hit || item.last_byte);
    end

    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        mc_next   = mc_reg;
        if (accept)
        begin
            if (item.last_byte)
            begin
                line_next = LINE_W'(1);
                col_next  = COL_W'(1);
                mc_next   = '0;
            end
            else
            begin
                mc_next = mc_inc;
                if (item.data_byte == NEWLINE_BYTE)
                begin
                    line_next = (line_reg != LINE_MAX) ? line_reg + 1'b1 : line_reg;
                    col_next  = COL_W'(1);
                end
                else if (col_reg != COL_MAX)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= LINE_W'(1);
            col_reg  <= COL_W'(1);
            mc_reg   <= '0;
        end
        else
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
            mc_reg   <= mc_next;
        end
    end

    fsmlc_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (pair),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
